### rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache table package
// Shared widths and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int SLOTS     = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int OCC_W     = $clog2(SLOTS + 1);
    localparam int USE_BITS  = 16;
    localparam int KEY_W     = 32;
    localparam int LIMIT_W   = 5;
    localparam int LIMIT_RST = 16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic capture;   // latch the input beat and search the table
        logic commit;    // apply the update and load the result register
    } lfu_ctl_t;

    typedef struct packed {
        logic dummy_ready;
    } lfu_sts_t;

endpackage

### rtl/lfu_datapath.sv
// ----------------------------------------------------------------------------
// LFU cache datapath
// Slot table, parallel key match, victim search and the result register.
// ----------------------------------------------------------------------------
module lfu_datapath
    import lfu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lfu_ctl_t                 ctl,
    input  logic [LIMIT_W-1:0]       limit_reg_in,
    input  logic                     cmd,
    input  logic signed [KEY_W-1:0]  key,
    input  logic signed [KEY_W-1:0]  data_in,
    output logic                     hit,
    output logic signed [KEY_W-1:0]  data_out,
    output logic                     evicted,
    output logic signed [KEY_W-1:0]  evicted_key,
    output lfu_sts_t                 sts
);

    logic [SLOTS-1:0]                 valid_reg;
    logic [KEY_W-1:0]                 key_mem   [SLOTS];
    logic [KEY_W-1:0]                 value_mem [SLOTS];
    logic [USE_BITS-1:0]              uses_mem  [SLOTS];
    logic [SLOT_W-1:0]                rank_mem  [SLOTS];
    logic [OCC_W-1:0]                 occ_reg;

    logic                             cmd_reg;
    logic [KEY_W-1:0]                 key_reg;
    logic [KEY_W-1:0]                 din_reg;
    logic                             found_reg;
    logic [SLOT_W-1:0]                found_idx_reg;
    logic                             victim_ok_reg;
    logic [SLOT_W-1:0]                victim_idx_reg;
    logic                             free_ok_reg;
    logic [SLOT_W-1:0]                free_idx_reg;
    logic [OCC_W-1:0]                 limit_reg;

    logic                             found_next;
    logic [SLOT_W-1:0]                found_idx_next;
    logic                             victim_ok_next;
    logic [SLOT_W-1:0]                victim_idx_next;
    logic                             free_ok_next;
    logic [SLOT_W-1:0]                free_idx_next;
    logic [OCC_W-1:0]                 limit_next;

    logic [USE_BITS+SLOT_W:0]         cand_score [SLOTS];
    logic [SLOT_W-1:0]                cand_idx   [SLOTS];

    assign sts.dummy_ready = 1'b1;

    // Search phase: match, victim and free slot, all against the stored table.
    always_comb
    begin
        found_next      = 1'b0;
        found_idx_next  = '0;
        free_ok_next    = 1'b0;
        free_idx_next   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_mem[i] == key)
            begin
                found_next     = 1'b1;
                found_idx_next = SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_ok_next  = 1'b1;
                free_idx_next = SLOT_W'(i);
            end
        end
        // A lower score wins: valid first, then the lowest count, then the oldest touch.
        for (int i = 0; i < SLOTS; i++)
        begin
            cand_score[i] = valid_reg[i] ? {1'b0, uses_mem[i], ~rank_mem[i]} : '1;
            cand_idx[i]   = SLOT_W'(i);
        end
        for (int lvl = 1; lvl < SLOTS; lvl = lvl * 2)
        begin
            for (int j = 0; j < SLOTS; j = j + 2 * lvl)
            begin
                if (cand_score[j + lvl] < cand_score[j])
                begin
                    cand_score[j] = cand_score[j + lvl];
                    cand_idx[j]   = cand_idx[j + lvl];
                end
            end
        end
        victim_ok_next  = |valid_reg;
        victim_idx_next = cand_idx[0];
        if (limit_reg_in > LIMIT_W'(SLOTS))
            limit_next = OCC_W'(SLOTS);
        else
            limit_next = OCC_W'(limit_reg_in);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg        <= cmd;
            key_reg        <= key;
            din_reg        <= data_in;
            found_reg      <= found_next;
            found_idx_reg  <= found_idx_next;
            victim_ok_reg  <= victim_ok_next;
            victim_idx_reg <= victim_idx_next;
            free_ok_reg    <= free_ok_next;
            free_idx_reg   <= free_idx_next;
            limit_reg      <= limit_next;
        end
    end

    // Commit phase decisions.
    logic                do_write;
    logic                do_evict;
    logic                do_insert;
    logic [SLOT_W-1:0]   tgt;
    logic [OCC_W-1:0]    old_rank;
    logic                age_all;

    always_comb
    begin
        do_evict  = 1'b0;
        do_insert = 1'b0;
        do_write  = 1'b0;
        tgt       = found_idx_reg;
        age_all   = 1'b0;
        if (found_reg && (cmd_reg == CMD_GET || limit_reg != '0))
            do_write = 1'b1;
        else if (cmd_reg == CMD_PUT && limit_reg != '0 && !found_reg)
        begin
            if (occ_reg >= limit_reg)
            begin
                do_evict = victim_ok_reg;
                tgt      = victim_idx_reg;
                do_write = victim_ok_reg;
            end
            else
            begin
                do_insert = free_ok_reg;
                tgt       = free_idx_reg;
                do_write  = free_ok_reg;
                age_all   = 1'b1;
            end
        end
        old_rank = OCC_W'(rank_mem[tgt]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end
        else if (ctl.commit && do_insert)
        begin
            valid_reg[tgt] <= 1'b1;
            occ_reg        <= occ_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit && do_write)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (SLOT_W'(i) != tgt && valid_reg[i]
                    && (age_all || OCC_W'(rank_mem[i]) < old_rank))
                    rank_mem[i] <= rank_mem[i] + SLOT_W'(1);
            end
            rank_mem[tgt] <= '0;
            if (found_reg)
            begin
                if (uses_mem[tgt] != {USE_BITS{1'b1}})
                    uses_mem[tgt] <= uses_mem[tgt] + USE_BITS'(1);
                if (cmd_reg == CMD_PUT)
                    value_mem[tgt] <= din_reg;
            end
            else
            begin
                uses_mem[tgt]  <= USE_BITS'(1);
                key_mem[tgt]   <= key_reg;
                value_mem[tgt] <= din_reg;
            end
        end
        if (ctl.commit)
        begin
            hit         <= found_reg;
            data_out    <= (found_reg && cmd_reg == CMD_GET) ? value_mem[found_idx_reg] : '0;
            evicted     <= do_evict;
            evicted_key <= do_evict ? key_mem[victim_idx_reg] : '0;
        end
    end

endmodule

### rtl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences search, commit and result hand-off for one beat at a time.
// ----------------------------------------------------------------------------
module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  lfu_sts_t sts,
    output lfu_ctl_t ctl
);

    typedef enum logic [1:0] {ST_IDLE, ST_COMMIT} state_t;

    state_t state_reg;
    logic   ov_reg;
    logic   out_free;

    // The result register may be reloaded once the old result leaves.
    assign out_free    = !ov_reg || !out_stall;
    assign in_stall    = (state_reg != ST_IDLE) || !sts.dummy_ready;
    assign ctl.capture = (state_reg == ST_IDLE) && in_valid;
    assign ctl.commit  = (state_reg == ST_COMMIT) && out_free;
    assign out_valid   = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.commit)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:   if (in_valid) state_reg <= ST_COMMIT;
                ST_COMMIT: if (out_free) state_reg <= ST_IDLE;
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### rtl/lfu_cache_table_core.sv
// ----------------------------------------------------------------------------
// LFU cache table core
// Sixteen-slot key/value store, least-frequently-used replacement with an
// oldest-touch tie break.
//
//   channel | direction | handshake
//   in      | input     | in_valid / in_stall, fields cmd, key, data_in
//   out     | output    | out_valid / out_stall, fields hit, data_out, ...
//   cfg     | input     | entry_limit_we / entry_limit_wdata
//
// Each beat runs in two phases: a search of all slots, then an update of the
// table and a load of the result register. The sequencing of these two phases
// sets the rate. A held result stalls the commit, and the input stays
// stalled until that commit is done.
// Reset clears the valid marks and sets the limit to sixteen.
// ----------------------------------------------------------------------------
module lfu_cache_table_core
    import lfu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     entry_limit_we,
    input  logic [LIMIT_W-1:0]       entry_limit_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     cmd,
    input  logic signed [KEY_W-1:0]  key,
    input  logic signed [KEY_W-1:0]  data_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     hit,
    output logic signed [KEY_W-1:0]  data_out,
    output logic                     evicted,
    output logic signed [KEY_W-1:0]  evicted_key
);

    logic [LIMIT_W-1:0] limit_reg;
    lfu_ctl_t           ctl;
    lfu_sts_t           sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_W'(LIMIT_RST);
        else if (entry_limit_we)
            limit_reg <= entry_limit_wdata;
    end

    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    lfu_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .limit_reg_in (limit_reg),
        .cmd          (cmd),
        .key          (key),
        .data_in      (data_in),
        .hit          (hit),
        .data_out     (data_out),
        .evicted      (evicted),
        .evicted_key  (evicted_key),
        .sts          (sts)
    );

    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.capture && ctl.commit))
        else $error("capture and commit in the same cycle");

    a_commit_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.capture |=> !in_valid || in_stall)
        else $error("input accepted during commit phase");

    a_evict_put: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> !hit && data_out == '0)
        else $error("eviction reported with a hit");

endmodule
